// ===== rtl/core/fss_pkg.sv =====
// fss_pkg: shared types, constants and character helpers of the fuzzy subsequence scorer
// no dependencies
`default_nettype none
package fss_pkg;

    localparam int QL_W    = 4;
    localparam int SCORE_W = 11;
    localparam int SUM_W   = SCORE_W - 1;
    localparam int Q100_W  = 10;
    localparam int NUM_W   = SUM_W + Q100_W;
    localparam int CNT_W   = $clog2(NUM_W);
    localparam int OUT_W   = 16;
    localparam int WIDE_W  = 64;

    localparam logic [SCORE_W-1:0] PTS_BASE     = SCORE_W'(10);
    localparam logic [SCORE_W-1:0] PTS_CASE     = SCORE_W'(5);
    localparam logic [SCORE_W-1:0] PTS_BOUNDARY = SCORE_W'(20);
    localparam logic [SCORE_W-1:0] PTS_FIRST    = SCORE_W'(30);
    localparam logic [SCORE_W-1:0] PTS_CONSEC   = SCORE_W'(15);
    localparam logic [Q100_W-1:0]  PERCENT      = Q100_W'(100);
    localparam logic [OUT_W-1:0]   SCORE_FULL   = OUT_W'(1000);
    localparam logic [OUT_W-1:0]   SCORE_TINY   = OUT_W'(1);

    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

    localparam logic [3:0] ADDR_QUERY_BYTES  = 4'h0;
    localparam logic [3:0] ADDR_QUERY_LENGTH = 4'h8;

    // result kind captured at the final byte
    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_LONG  = 3'd1;
    localparam logic [2:0] KIND_EMPTY = 3'd2;
    localparam logic [2:0] KIND_NEG   = 3'd3;
    localparam logic [2:0] KIND_DIV   = 3'd4;

    typedef struct packed {
        logic [WIDE_W-1:0] query_bytes;
        logic [QL_W-1:0]   query_length;
    } t_cfg;

    typedef struct packed {
        logic step;
        logic mul;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic needs_div;
    } t_sts;

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_upper(c) || is_lower(c) || ((c >= 8'h30) && (c <= 8'h39));
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return is_upper(c) ? (c + 8'd32) : c;
    endfunction

    function automatic logic at_boundary(input logic first, input logic [7:0] prev,
                                         input logic [7:0] cur);
        return first
            || ((prev == CHAR_UNDERSCORE) && (cur != CHAR_UNDERSCORE))
            || (is_lower(prev) && is_upper(cur))
            || (!is_alnum(prev) && is_alnum(cur));
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/fss_in_if.sv =====
// fss_in_if: text byte channel, valid/ready with source and sink modports
// no dependencies
`default_nettype none
interface fss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/fss_out_if.sv =====
// fss_out_if: result channel, valid/ready with source and sink modports
// no dependencies
`default_nettype none
interface fss_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] match_score;
    logic        matched;
    logic [63:0] position_mask;
    logic        text_too_long;

    modport source (output valid, output match_score, output matched,
                    output position_mask, output text_too_long, input ready);
    modport sink   (input valid, input match_score, input matched,
                    input position_mask, input text_too_long, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/fss_cfg.sv =====
// fss_cfg: apb register file holding the query bytes and query length
// depends on fss_pkg
`default_nettype none
module fss_cfg (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [3:0]                paddr,
    input  wire logic [63:0]               pwdata,
    output logic      [63:0]               prdata,
    output logic                           pready,
    output fss_pkg::t_cfg                  o_cfg
);

    logic [fss_pkg::WIDE_W-1:0] r_query_bytes;
    logic [fss_pkg::QL_W-1:0]   r_query_length;
    logic                       wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_bytes  <= '0;
            r_query_length <= '0;
        end else if (wr_en) begin
            if (paddr[3] == fss_pkg::ADDR_QUERY_LENGTH[3]) begin
                r_query_length <= pwdata[fss_pkg::QL_W-1:0];
            end else begin
                r_query_bytes <= pwdata;
            end
        end
    end

    always_comb begin
        if (paddr[3] == fss_pkg::ADDR_QUERY_LENGTH[3]) begin
            prdata = 64'(r_query_length);
        end else begin
            prdata = r_query_bytes;
        end
    end

    assign o_cfg.query_bytes  = r_query_bytes;
    assign o_cfg.query_length = r_query_length;

endmodule
`default_nettype wire

// ===== rtl/core/fss_dp.sv =====
// fss_dp: datapath with per-byte match scoring, final multiply, restoring divider, result regs
// depends on fss_pkg
`default_nettype none
module fss_dp #(
    parameter int MAX_QUERY = 8,
    parameter int MAX_TEXT  = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire fss_pkg::t_cmd                 i_cmd,
    output fss_pkg::t_sts                      o_sts,
    input  wire fss_pkg::t_cfg                 i_cfg,
    input  wire logic [7:0]                    i_text_char,
    input  wire logic                          i_last_char,
    output logic      [fss_pkg::OUT_W-1:0]     o_match_score,
    output logic                               o_matched,
    output logic      [fss_pkg::WIDE_W-1:0]    o_position_mask,
    output logic                               o_text_too_long
);

    localparam int PW = $clog2(MAX_TEXT + 1);
    localparam int IW = $clog2(MAX_TEXT);
    localparam int QL_W = fss_pkg::QL_W;
    localparam int SCORE_W = fss_pkg::SCORE_W;
    localparam int NUM_W = fss_pkg::NUM_W;

    // candidate state
    logic [QL_W-1:0]           r_qidx,     n_qidx;
    logic [PW-1:0]             r_pos,      n_pos;
    logic [7:0]                r_prev,     n_prev;
    logic [PW-1:0]             r_last_pos, n_last_pos;
    logic signed [SCORE_W-1:0] r_score,    n_score;
    logic [MAX_TEXT-1:0]       r_bits,     n_bits;
    logic                      r_ovf,      n_ovf;

    // final snapshot and arithmetic
    logic [2:0]                    r_kind,  n_kind;
    logic [fss_pkg::SUM_W-1:0]     r_f_sum;
    logic [fss_pkg::Q100_W-1:0]    r_f_q100;
    logic [PW-1:0]                 r_f_tlen;
    logic [MAX_TEXT-1:0]           r_f_mask;
    logic [NUM_W-1:0]              r_num;
    logic [PW-1:0]                 r_rem;

    logic [QL_W-1:0]           qlen;
    logic                      examine;
    logic                      hit;
    logic [7:0]                qc;
    logic [PW-1:0]             gap;
    logic signed [SCORE_W-1:0] pts;
    logic [NUM_W-1:0]          prod;
    logic [PW:0]               trial;
    logic                      take;

    assign qlen = (i_cfg.query_length > QL_W'(MAX_QUERY)) ? QL_W'(MAX_QUERY)
                                                          : i_cfg.query_length;

    always_comb begin
        examine = r_pos < PW'(MAX_TEXT);
        qc      = i_cfg.query_bytes[8*r_qidx[2:0] +: 8];
        hit     = examine && (r_qidx < qlen)
               && (fss_pkg::fold_case(i_text_char) == fss_pkg::fold_case(qc));
        gap     = r_pos - r_last_pos - PW'(1);

        pts = fss_pkg::PTS_BASE;
        if (i_text_char == qc) begin
            pts = pts + fss_pkg::PTS_CASE;
        end
        if (fss_pkg::at_boundary(r_pos == '0, r_prev, i_text_char)) begin
            pts = pts + fss_pkg::PTS_BOUNDARY;
        end
        if (r_pos == '0) begin
            pts = pts + fss_pkg::PTS_FIRST;
        end
        if (r_qidx != '0) begin
            if (r_last_pos + PW'(1) == r_pos) begin
                pts = pts + fss_pkg::PTS_CONSEC;
            end
            pts = pts - signed'(SCORE_W'(gap));
        end

        n_qidx     = r_qidx;
        n_pos      = r_pos;
        n_prev     = r_prev;
        n_last_pos = r_last_pos;
        n_score    = r_score;
        n_bits     = r_bits;
        n_ovf      = r_ovf;
        if (!examine) begin
            n_ovf = 1'b1;
        end else begin
            if (hit) begin
                n_score          = r_score + pts;
                n_bits[r_pos[IW-1:0]] = 1'b1;
                n_last_pos       = r_pos;
                n_qidx           = r_qidx + QL_W'(1);
            end
            n_prev = i_text_char;
            n_pos  = r_pos + PW'(1);
        end

        if (n_ovf) begin
            n_kind = fss_pkg::KIND_LONG;
        end else if (qlen == '0) begin
            n_kind = fss_pkg::KIND_EMPTY;
        end else if ((n_qidx >= qlen) && (8'(qlen) <= 8'(n_pos))) begin
            n_kind = n_score[SCORE_W-1] ? fss_pkg::KIND_NEG : fss_pkg::KIND_DIV;
        end else begin
            n_kind = fss_pkg::KIND_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qidx     <= '0;
            r_pos      <= '0;
            r_prev     <= '0;
            r_last_pos <= '0;
            r_score    <= '0;
            r_bits     <= '0;
            r_ovf      <= 1'b0;
            r_kind     <= fss_pkg::KIND_NONE;
        end else if (i_cmd.step) begin
            if (i_last_char) begin
                r_qidx     <= '0;
                r_pos      <= '0;
                r_prev     <= '0;
                r_last_pos <= '0;
                r_score    <= '0;
                r_bits     <= '0;
                r_ovf      <= 1'b0;
                r_kind     <= n_kind;
            end else begin
                r_qidx     <= n_qidx;
                r_pos      <= n_pos;
                r_prev     <= n_prev;
                r_last_pos <= n_last_pos;
                r_score    <= n_score;
                r_bits     <= n_bits;
                r_ovf      <= n_ovf;
            end
        end
    end

    // snapshot at the final byte
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && i_last_char) begin
            r_f_sum  <= n_score[fss_pkg::SUM_W-1:0];
            r_f_q100 <= fss_pkg::Q100_W'(qlen) * fss_pkg::PERCENT;
            r_f_tlen <= n_pos;
            r_f_mask <= n_bits;
        end
    end

    assign prod  = NUM_W'(r_f_sum) * NUM_W'(r_f_q100);
    assign trial = {r_rem, r_num[NUM_W-1]};
    assign take  = trial >= {1'b0, r_f_tlen};

    // restoring divide, quotient shifts into r_num
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_num <= prod;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[NUM_W-2:0], take};
            r_rem <= take ? PW'(trial - {1'b0, r_f_tlen}) : trial[PW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            case (r_kind)
                fss_pkg::KIND_LONG: begin
                    o_match_score   <= '0;
                    o_matched       <= 1'b0;
                    o_position_mask <= '0;
                    o_text_too_long <= 1'b1;
                end
                fss_pkg::KIND_EMPTY: begin
                    o_match_score   <= fss_pkg::SCORE_FULL;
                    o_matched       <= 1'b1;
                    o_position_mask <= '0;
                    o_text_too_long <= 1'b0;
                end
                fss_pkg::KIND_NEG: begin
                    o_match_score   <= fss_pkg::SCORE_TINY;
                    o_matched       <= 1'b1;
                    o_position_mask <= fss_pkg::WIDE_W'(r_f_mask);
                    o_text_too_long <= 1'b0;
                end
                fss_pkg::KIND_DIV: begin
                    o_match_score   <= r_num[fss_pkg::OUT_W-1:0];
                    o_matched       <= 1'b1;
                    o_position_mask <= fss_pkg::WIDE_W'(r_f_mask);
                    o_text_too_long <= 1'b0;
                end
                default: begin
                    o_match_score   <= '0;
                    o_matched       <= 1'b0;
                    o_position_mask <= '0;
                    o_text_too_long <= 1'b0;
                end
            endcase
        end
    end

    assign o_sts.needs_div = (r_kind == fss_pkg::KIND_DIV);

endmodule
`default_nettype wire

// ===== rtl/core/fss_ctrl.sv =====
// fss_ctrl: sequencer for byte intake, final multiply, divide steps and result hand-off
// depends on fss_pkg
`default_nettype none
module fss_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_last,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output fss_pkg::t_cmd      o_cmd,
    input  wire fss_pkg::t_sts i_sts
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                 r_state, n_state;
    logic [fss_pkg::CNT_W-1:0]  r_cnt,   n_cnt;
    logic                       r_out_valid, n_out_valid;

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.step = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_state   = i_sts.needs_div ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == fss_pkg::CNT_W'(fss_pkg::NUM_W - 1)) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt + fss_pkg::CNT_W'(1);
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = o_cmd.load_out || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== rtl/core/fuzzy_subsequence_scorer.sv =====
// fuzzy_subsequence_scorer: top level joining apb registers, sequencer and datapath
// depends on fss_pkg, fss_in_if, fss_out_if, fss_cfg, fss_ctrl, fss_dp
//
// channel    dir  transaction  payload
// i_text     in   one byte     text_char[7:0], last_char
// o_result   out  one result   match_score[15:0], matched, position_mask[63:0], text_too_long
// apb        in   reg write    query_bytes at 0x0, query_length at 0x8
//
// one text byte per cycle while the sequencer is idle; the final byte is followed by a multiply,
// then, when a divide is needed, restoring divide steps, one per quotient bit, then the result register load
// bytes are held off from the final byte until the result register is loaded
// a waiting result holds in its register while the next candidate streams in
// synchronous active-low reset clears the apb registers, the sequencer state and the candidate state
`default_nettype none
module fuzzy_subsequence_scorer #(
    parameter int MAX_QUERY = 8,
    parameter int MAX_TEXT  = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    fss_in_if.sink           i_text,
    fss_out_if.source        o_result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready
);

    fss_pkg::t_cfg cfg;
    fss_pkg::t_cmd cmd;
    fss_pkg::t_sts sts;

    fss_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_text.valid),
        .i_in_last   (i_text.last_char),
        .o_in_ready  (i_text.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    fss_dp #(
        .MAX_QUERY (MAX_QUERY),
        .MAX_TEXT  (MAX_TEXT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg           (cfg),
        .i_text_char     (i_text.text_char),
        .i_last_char     (i_text.last_char),
        .o_match_score   (o_result.match_score),
        .o_matched       (o_result.matched),
        .o_position_mask (o_result.position_mask),
        .o_text_too_long (o_result.text_too_long)
    );

endmodule
`default_nettype wire
